// ----- src/pcsf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsf_pkg: shared types and constants of the proxy client session controller
// Transaction payloads, state and action codes, pending flag bit positions.
// ----------------------------------------------------------------------------
package pcsf_pkg;

   localparam int unsigned TIME_W     = 48;
   localparam int unsigned ID_W       = 64;
   localparam int unsigned INTERVAL_W = 32;
   localparam int unsigned FLAGS_W    = 7;

   localparam logic [INTERVAL_W-1:0] NOP_INTERVAL_RESET = 32'd10000;

   // pending flag bit positions
   localparam int unsigned FLAG_CONNECTED  = 0;
   localparam int unsigned FLAG_CLOSED     = 1;
   localparam int unsigned FLAG_LINK       = 2;
   localparam int unsigned FLAG_SERVER_MSG = 3;
   localparam int unsigned FLAG_ID         = 4;
   localparam int unsigned FLAG_FINISH     = 5;
   localparam int unsigned FLAG_OUT        = 6;

   typedef enum logic [3:0] {
      ST_BEGIN          = 4'd0,
      ST_INITIALIZE     = 4'd1,
      ST_WAIT_CONNECT   = 4'd2,
      ST_ACCEPT         = 4'd3,
      ST_START_TRANSFER = 4'd4,
      ST_WAITING        = 4'd5,
      ST_CLOSED         = 4'd6,
      ST_LINK_STATUS    = 4'd7,
      ST_RECEIVE_MSG    = 4'd8,
      ST_SEND_MSG       = 4'd9,
      ST_ID_ASSIGNED    = 4'd10,
      ST_SEND_NOP       = 4'd11,
      ST_FINISH         = 4'd12,
      ST_END            = 4'd13
   } sess_state_type;

   typedef enum logic [3:0] {
      ACT_NONE    = 4'd0,
      ACT_CONNECT = 4'd1,
      ACT_HTTP    = 4'd2,
      ACT_CLOSE   = 4'd3,
      ACT_ID_REQ  = 4'd4,
      ACT_LINK    = 4'd5,
      ACT_PROCESS = 4'd6,
      ACT_SEND    = 4'd7,
      ACT_NEW_ID  = 4'd8,
      ACT_NOP     = 4'd9
   } action_type;

   typedef struct packed {
      logic              start_req;
      logic [ID_W-1:0]   preferred_id;
      logic [TIME_W-1:0] current_time;
      logic              tcp_connected;
      logic              tcp_closed;
      logic              link_status_in;
      logic              server_msg_in;
      logic              id_assigned;
      logic [ID_W-1:0]   new_id;
      logic              finish_request;
      logic              http_ok;
      logic              send_request;
   } req_type;

   typedef struct packed {
      logic [3:0]      fsm_state;
      logic [3:0]      action_code;
      logic [ID_W-1:0] active_id;
      logic            send_accepted;
   } rsp_type;

   typedef struct packed {
      sess_state_type     state;
      logic [FLAGS_W-1:0] flags;
      logic [TIME_W-1:0]  nop_deadline;
      logic [ID_W-1:0]    current_entity;
      logic [ID_W-1:0]    assigned_entity;
   } sess_type;

endpackage

// ----- src/pcsf_step.sv -----
// ----------------------------------------------------------------------------
// pcsf_step: one session step
// Applies start, flag raising, one state transition and send acceptance to
// the session context for one transaction.
// ----------------------------------------------------------------------------
module pcsf_step (
   input  pcsf_pkg::sess_type                       sess_cur,
   input  pcsf_pkg::req_type                        item,
   input  logic [pcsf_pkg::INTERVAL_W-1:0]          nop_interval,
   output pcsf_pkg::sess_type                       sess_next,
   output pcsf_pkg::rsp_type                        rsp
);

   pcsf_pkg::sess_type               ctx;
   pcsf_pkg::action_type             act;
   logic                             accepted;
   logic [pcsf_pkg::TIME_W-1:0]      restart_val;
   logic                             nop_due;

   // keepalive deadline wraps modulo 2^48
   assign restart_val = item.current_time
                        + {{(pcsf_pkg::TIME_W-pcsf_pkg::INTERVAL_W){1'b0}}, nop_interval};
   assign nop_due     = item.current_time > sess_cur.nop_deadline;

   always_comb begin
      ctx      = sess_cur;
      act      = pcsf_pkg::ACT_NONE;
      accepted = 1'b0;

      if (item.start_req) begin
         ctx.current_entity = item.preferred_id;
         ctx.state          = pcsf_pkg::ST_BEGIN;
      end

      if (item.tcp_connected)  ctx.flags[pcsf_pkg::FLAG_CONNECTED]  = 1'b1;
      if (item.tcp_closed)     ctx.flags[pcsf_pkg::FLAG_CLOSED]     = 1'b1;
      if (item.link_status_in) ctx.flags[pcsf_pkg::FLAG_LINK]       = 1'b1;
      if (item.server_msg_in)  ctx.flags[pcsf_pkg::FLAG_SERVER_MSG] = 1'b1;
      if (item.id_assigned) begin
         ctx.flags[pcsf_pkg::FLAG_ID] = 1'b1;
         ctx.assigned_entity          = item.new_id;
      end
      if (item.finish_request) ctx.flags[pcsf_pkg::FLAG_FINISH]     = 1'b1;

      if (!item.start_req) begin
         unique case (ctx.state)
            pcsf_pkg::ST_BEGIN: begin
               ctx.state = pcsf_pkg::ST_INITIALIZE;
               ctx.flags = '0;
               act       = pcsf_pkg::ACT_CONNECT;
            end
            pcsf_pkg::ST_INITIALIZE: begin
               ctx.state = pcsf_pkg::ST_WAIT_CONNECT;
            end
            pcsf_pkg::ST_WAIT_CONNECT: begin
               if (ctx.flags[pcsf_pkg::FLAG_CONNECTED]) begin
                  ctx.state = pcsf_pkg::ST_ACCEPT;
                  act       = pcsf_pkg::ACT_HTTP;
               end else if (ctx.flags[pcsf_pkg::FLAG_FINISH]) begin
                  ctx.state = pcsf_pkg::ST_FINISH;
               end
            end
            pcsf_pkg::ST_ACCEPT: begin
               if (item.http_ok) begin
                  ctx.state        = pcsf_pkg::ST_START_TRANSFER;
                  ctx.nop_deadline = restart_val;
                  act              = pcsf_pkg::ACT_ID_REQ;
               end else begin
                  ctx.state = pcsf_pkg::ST_CLOSED;
                  act       = pcsf_pkg::ACT_CLOSE;
               end
            end
            pcsf_pkg::ST_WAITING: begin
               // fixed priority, keepalive deadline checked last
               priority if (ctx.flags[pcsf_pkg::FLAG_CLOSED]
                            || ctx.flags[pcsf_pkg::FLAG_FINISH]) begin
                  ctx.state = pcsf_pkg::ST_CLOSED;
                  act       = pcsf_pkg::ACT_CLOSE;
               end else if (ctx.flags[pcsf_pkg::FLAG_LINK]) begin
                  ctx.state                      = pcsf_pkg::ST_LINK_STATUS;
                  ctx.flags[pcsf_pkg::FLAG_LINK] = 1'b0;
                  act                            = pcsf_pkg::ACT_LINK;
               end else if (ctx.flags[pcsf_pkg::FLAG_SERVER_MSG]) begin
                  ctx.state                            = pcsf_pkg::ST_RECEIVE_MSG;
                  ctx.flags[pcsf_pkg::FLAG_SERVER_MSG] = 1'b0;
                  act                                  = pcsf_pkg::ACT_PROCESS;
               end else if (ctx.flags[pcsf_pkg::FLAG_OUT]) begin
                  ctx.state                     = pcsf_pkg::ST_SEND_MSG;
                  ctx.flags[pcsf_pkg::FLAG_OUT] = 1'b0;
                  ctx.nop_deadline              = restart_val;
                  act                           = pcsf_pkg::ACT_SEND;
               end else if (ctx.flags[pcsf_pkg::FLAG_ID]) begin
                  ctx.state                    = pcsf_pkg::ST_ID_ASSIGNED;
                  ctx.current_entity           = ctx.assigned_entity;
                  ctx.flags[pcsf_pkg::FLAG_ID] = 1'b0;
                  ctx.nop_deadline             = restart_val;
                  act                          = pcsf_pkg::ACT_NEW_ID;
               end else if (nop_due) begin
                  ctx.state        = pcsf_pkg::ST_SEND_NOP;
                  ctx.nop_deadline = restart_val;
                  act              = pcsf_pkg::ACT_NOP;
               end else begin
                  ctx.state = pcsf_pkg::ST_WAITING;
               end
            end
            pcsf_pkg::ST_CLOSED: begin
               ctx.state = pcsf_pkg::ST_FINISH;
            end
            pcsf_pkg::ST_START_TRANSFER,
            pcsf_pkg::ST_LINK_STATUS,
            pcsf_pkg::ST_RECEIVE_MSG,
            pcsf_pkg::ST_SEND_MSG,
            pcsf_pkg::ST_ID_ASSIGNED,
            pcsf_pkg::ST_SEND_NOP: begin
               ctx.state = pcsf_pkg::ST_WAITING;
            end
            default: begin
               ctx.state = pcsf_pkg::ST_END;
            end
         endcase
      end

      if (item.send_request && !ctx.flags[pcsf_pkg::FLAG_OUT]) begin
         ctx.flags[pcsf_pkg::FLAG_OUT] = 1'b1;
         accepted                      = 1'b1;
      end
   end

   assign sess_next         = ctx;
   assign rsp.fsm_state     = ctx.state;
   assign rsp.action_code   = act;
   assign rsp.active_id     = ctx.current_entity;
   assign rsp.send_accepted = accepted;

endmodule

// ----- src/proxy_client_session_fsm_top.sv -----
// ----------------------------------------------------------------------------
// proxy_client_session_fsm_top: proxy client session controller
// Fourteen-state session machine with event flags and keepalive deadline.
//
//   channel  direction  handshake        payload
//   req_     in         valid / stall    pcsf_pkg::req_type
//   rsp_     out        valid / stall    pcsf_pkg::rsp_type
//   csr_     in         valid / ready    nop_interval, 32 bits
//
// One transaction per cycle sustained while rsp_stall is low; an accepted
// transaction enters the hold register, then the result register that drives rsp_.
// The session context updates when a transaction moves into the result
// register, so back-to-back transactions see each other's effect.
// rsp_stall reaches req_stall in the same cycle once the hold register is full.
// Synchronous reset puts the session in END with all flags clear and
// nop_interval at 10000.
// ----------------------------------------------------------------------------
module proxy_client_session_fsm_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pcsf_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pcsf_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pcsf_pkg::INTERVAL_W-1:0]        csr_data
);

   logic                                hold_valid_ff;
   pcsf_pkg::req_type                   hold_item_ff;
   logic                                rsp_valid_ff;
   pcsf_pkg::rsp_type                   rsp_ff;
   pcsf_pkg::rsp_type                   rsp_in;
   pcsf_pkg::sess_type                  sess_ff;
   pcsf_pkg::sess_type                  sess_in;
   logic [pcsf_pkg::INTERVAL_W-1:0]     nop_interval_ff;
   logic                                req_take;
   logic                                advance;

   assign advance   = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = hold_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   pcsf_step u_step (
      .sess_cur     (sess_ff),
      .item         (hold_item_ff),
      .nop_interval (nop_interval_ff),
      .sess_next    (sess_in),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff           <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         nop_interval_ff         <= pcsf_pkg::NOP_INTERVAL_RESET;
         sess_ff.state           <= pcsf_pkg::ST_END;
         sess_ff.flags           <= '0;
         sess_ff.nop_deadline    <= '0;
         sess_ff.current_entity  <= '0;
         sess_ff.assigned_entity <= '0;
      end else begin
         if (req_take) begin
            hold_valid_ff <= 1'b1;
         end else if (advance) begin
            hold_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            sess_ff      <= sess_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            nop_interval_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
